/* src/ulmf_pkg.sv */
// Shared types and constants for the ultrasonic level median filter.
// No dependencies; used by ulmf_ctrl, ulmf_dp and the top level.
package ulmf_pkg;

	localparam int EchoW = 16;
	localparam int LevelW = 17;
	localparam int ProdW = 29;
	localparam int DistW = 19;
	localparam int SpeedShift = 10;

	localparam logic [12:0] SPEED_NUM = 13'd4496;
	localparam logic [DistW-1:0] DIST_MIN = 19'd512;
	localparam logic [DistW-1:0] DIST_MAX = 19'd102400;

	localparam logic [LevelW-1:0] MOUNT_RESET = 17'd51200;
	localparam logic [LevelW-1:0] ALARM_RESET = 17'd38400;

	localparam int AddrW = 3;
	localparam logic REG_MOUNT = 1'b0;
	localparam logic REG_ALARM = 1'b1;

	typedef struct packed {
		logic load;
		logic write;
		logic sweep;
		logic median;
		logic level;
		logic publish;
	} ulmf_cmd_t;

	typedef struct packed {
		logic ok;
		logic sweep_last;
		logic out_busy;
	} ulmf_sts_t;

endpackage

/* src/ulmf_dp.sv */
// Datapath: distance multiply, range check, distance ring memory, rank-count
// median sweep, level clamp and output register. Depends on ulmf_pkg.
module ulmf_dp
	import ulmf_pkg::*;
#(
	parameter int WINDOW = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ulmf_cmd_t         cmd,
	output ulmf_sts_t         sts,
	input  logic [EchoW-1:0]  echo_us,
	input  logic [LevelW-1:0] mount_height,
	input  logic [LevelW-1:0] alarm_level,
	output logic [LevelW-1:0] water_level,
	output logic              reading_ok,
	output logic              alarm,
	output logic              out_valid,
	input  logic              out_ready
);

	localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW = $clog2(WINDOW + 1);

	logic [LevelW-1:0] ring_mem [WINDOW];

	logic [ProdW-1:0]  prod;
	logic [DistW-1:0]  dist_q;
	logic              ok_q;
	logic [IW-1:0]     slot_q;
	logic              full_q;
	logic [CW-1:0]     n_q;
	logic [IW-1:0]     i_q, j_q;
	logic [IW-1:0]     i_s1, j_s1;
	logic              v_s1, jlast_s1;
	logic [LevelW-1:0] a_s1, b_s1;
	logic [CW-1:0]     rank_q;
	logic [LevelW-1:0] med_lo_q, med_hi_q, med_q, held_q;
	logic [LevelW-1:0] out_level_q;
	logic              out_ok_q, out_alarm_q, out_valid_q;

	logic              slot_wrap;
	logic [IW-1:0]     slot_next;
	logic              full_next;
	logic [CW-1:0]     last_idx;
	logic              i_last, j_last;
	logic              lt;
	logic [CW-1:0]     rank_cur, lo_rank, hi_rank;
	logic [LevelW:0]   med_sum;

	assign prod = ProdW'(echo_us) * ProdW'(SPEED_NUM);

	assign slot_wrap = (slot_q == IW'(WINDOW - 1));
	assign slot_next = slot_wrap ? '0 : slot_q + 1'b1;
	assign full_next = full_q | slot_wrap;

	assign last_idx = n_q - 1'b1;
	assign i_last = (CW'(i_q) == last_idx);
	assign j_last = (CW'(j_q) == last_idx);

	assign lt = (b_s1 < a_s1) || ((b_s1 == a_s1) && (j_s1 < i_s1));
	assign rank_cur = ((j_s1 == '0) ? '0 : rank_q) + CW'(lt);
	assign lo_rank = last_idx >> 1;
	assign hi_rank = n_q >> 1;
	assign med_sum = {1'b0, med_lo_q} + {1'b0, med_hi_q};

	assign sts.ok = (dist_q >= DIST_MIN) && (dist_q <= DIST_MAX);
	assign sts.sweep_last = i_last && j_last;
	assign sts.out_busy = out_valid_q && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dist_q <= prod[ProdW-1:SpeedShift];
		end
		if (cmd.write) begin
			ring_mem[slot_q] <= dist_q[LevelW-1:0];
		end
		a_s1 <= ring_mem[i_q];
		b_s1 <= ring_mem[j_q];
		i_s1 <= i_q;
		j_s1 <= j_q;
		jlast_s1 <= j_last;
		if (v_s1) begin
			rank_q <= rank_cur;
			if (jlast_s1 && rank_cur == lo_rank) begin
				med_lo_q <= a_s1;
			end
			if (jlast_s1 && rank_cur == hi_rank) begin
				med_hi_q <= a_s1;
			end
		end
		if (cmd.median) begin
			med_q <= med_sum[LevelW:1];
		end
		if (cmd.publish) begin
			out_level_q <= held_q;
			out_ok_q <= ok_q;
			out_alarm_q <= (held_q >= alarm_level);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
			slot_q <= '0;
			full_q <= 1'b0;
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			v_s1 <= 1'b0;
			held_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.sweep;
			if (cmd.load) begin
				ok_q <= 1'b0;
			end
			if (cmd.write) begin
				ok_q <= 1'b1;
				slot_q <= slot_next;
				full_q <= full_next;
				n_q <= full_next ? CW'(WINDOW) : CW'(slot_next);
				i_q <= '0;
				j_q <= '0;
			end else if (cmd.sweep) begin
				if (j_last) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			if (cmd.level) begin
				held_q <= (med_q >= mount_height) ? '0 : mount_height - med_q;
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign water_level = out_level_q;
	assign reading_ok = out_ok_q;
	assign alarm = out_alarm_q;
	assign out_valid = out_valid_q;

endmodule

/* src/ulmf_ctrl.sv */
// Controller state machine: sequences load, range check, ring write, median
// sweep, level update and result hand-off. Depends on ulmf_pkg.
module ulmf_ctrl
	import ulmf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output ulmf_cmd_t cmd,
	input  ulmf_sts_t sts
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_CHECK  = 7'b0000010,
		ST_SWEEP  = 7'b0000100,
		ST_DRAIN  = 7'b0001000,
		ST_MEDIAN = 7'b0010000,
		ST_LEVEL  = 7'b0100000,
		ST_RESULT = 7'b1000000
	} ulmf_state_t;

	ulmf_state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.ok) begin
					cmd.write = 1'b1;
					state_d = ST_SWEEP;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_MEDIAN;
			end
			ST_MEDIAN: begin
				cmd.median = 1'b1;
				state_d = ST_LEVEL;
			end
			ST_LEVEL: begin
				cmd.level = 1'b1;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!sts.out_busy) begin
					cmd.publish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* src/ultrasonic_level_median_filter.sv */
// Ultrasonic tank level with running median filter: top level.
// Holds the APB registers and joins ulmf_ctrl and ulmf_dp; uses ulmf_pkg.
//
// Usage: each s_tdata word is one echo width in us (0 = timeout). Every word
// gives exactly one m_tdata word: water level, alarm, and m_tuser = reading ok.
// A rejected echo (timeout, under 2 cm or over 400 cm) repeats the last level.
// Items are handled one at a time, each published before the next is taken.
//   A rejected echo goes from the range check straight to the result step; a
//   good echo is written to the ring, swept, and its median and level set. The
//   pairwise rank sweep over the ring memory makes n*n compares, one per cycle,
//   n = entries in the median (<= WINDOW).
// s_tready is high only while the block waits for an echo; an output register
// holds the result, so the next echo is taken while m_tvalid waits. A stalled
// receiver holds the block in its last step until the register frees up.
// Reset empties the ring, zeroes the held level and loads the default mount
// height (200 cm) and alarm level (150 cm). Registers (APB, pready always high):
//   0x0 mount_height, 0x4 alarm_level; write only while no item is in flight.
module ultrasonic_level_median_filter
	import ulmf_pkg::*;
#(
	parameter int WINDOW = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [15:0]      s_tdata,   // [15:0] echo_us
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,   // [16:0] water_level, [17] alarm, rest zero
	output logic             m_tuser,   // [0] reading_ok
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [LevelW-1:0] mount_q, alarm_q;
	logic [LevelW-1:0] water_level;
	logic              alarm;
	logic              cfg_wr;
	ulmf_cmd_t         cmd;
	ulmf_sts_t         sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mount_q <= MOUNT_RESET;
			alarm_q <= ALARM_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_MOUNT) begin
				mount_q <= pwdata[LevelW-1:0];
			end
			if (paddr[2] == REG_ALARM) begin
				alarm_q <= pwdata[LevelW-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_ALARM) ? 32'(alarm_q) : 32'(mount_q);

	ulmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	ulmf_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.echo_us      (s_tdata),
		.mount_height (mount_q),
		.alarm_level  (alarm_q),
		.water_level  (water_level),
		.reading_ok   (m_tuser),
		.alarm        (alarm),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready)
	);

	assign m_tdata = {6'b0, alarm, water_level};

	a_ok_level_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> water_level <= mount_q)
		else $error("fresh level above mount height");

	a_alarm_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> alarm == (water_level >= alarm_q))
		else $error("alarm flag disagrees with level");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second echo taken while busy");

endmodule
